// ----- rtl/fpa_pkg.sv -----
// fpa_pkg: shared types and codes of the fit policy partition allocator.
// Holds the transaction structs, request and policy codes, register indexes.
// No dependencies.
package fpa_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(1);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } pol_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  block_index;
    logic [15:0] size_value;
    logic        last_request;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_index;
    logic [15:0] remaining_size;
  } rsp_t;

endpackage

// ----- rtl/fit_policy_partition_allocator.sv -----
// fit_policy_partition_allocator: top level of the partition allocator.
// Holds the configuration registers and joins fpa_scan and fpa_table.
// Depends on fpa_pkg, fpa_table and fpa_scan.
//
// Usage:
//   Configuration: cfg_we, cfg_index, cfg_wdata write fit_policy (index 0)
//   or block_count (index 1), one register per write, taking effect at the
//   write edge; other indexes are ignored.
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. A load writes one partition's free size; an allocate searches the
//   partitions in use under the selected policy and debits the pick.
//   Output: rsp is valid for exactly one cycle with done high; the receiver
//   cannot hold it off.
//   Sequence: a load, an out-of-range load or an allocate with no partition
//   in use answers without a scan and busy stays low. An allocate reads
//   the partitions in use, one table read per cycle on the single read port,
//   in ST_SCAN, settles the last compare in ST_LAST, writes back the debit
//   in ST_DONE and then shows the result on rsp. busy is high in ST_SCAN,
//   ST_LAST and ST_DONE and drops in the result cycle, so the next
//   transaction can be taken at the edge that ends the result.
//   Reset: rst clears the sequencer and the next fit pointer, sets
//   fit_policy to first fit and block_count to 16. The table is not
//   cleared; a partition must be loaded before it is searched.
module fit_policy_partition_allocator
  import fpa_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  rsp
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  pol_t                  fit_policy;
  logic [4:0]            block_count;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [SIZE_WIDTH-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POL_FIRST;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_POLICY:  fit_policy  <= pol_t'(cfg_wdata[1:0]);
        CFG_BLOCK_COUNT: block_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fpa_scan #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .fit_policy  (fit_policy),
    .block_count (block_count),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  fpa_table #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_WIDTH),
    .AW    (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ----- rtl/fpa_table.sv -----
// fpa_table: free size table, one write port and one read port.
// Read data is registered. Depends on nothing.
module fpa_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/fpa_scan.sv -----
// fpa_scan: sequencer of the partition allocator.
// Writes loads into the free size table, scans it one entry a cycle, keeps
// the pick, writes back the debit and issues the result. Depends on fpa_pkg.
module fpa_scan
  import fpa_pkg::*;
#(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  rsp,
  input  pol_t                  fit_policy,
  input  logic [4:0]            block_count,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [SIZE_WIDTH-1:0] wr_data,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  logic [SIZE_WIDTH-1:0] rd_data
);

  state_t                state;
  logic [SIZE_WIDTH-1:0] req_size;
  logic                  req_last;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      pos;
  logic [CNT_W-1:0]      left;
  logic                  d_valid;
  logic [IDX_W-1:0]      d_idx;
  logic                  found;
  logic [IDX_W-1:0]      pick_idx;
  logic [SIZE_WIDTH-1:0] pick_val;
  logic [IDX_W-1:0]      rover;

  logic                  accept;
  logic                  load_ok;
  logic [CNT_W-1:0]      used_cnt;
  logic [IDX_W-1:0]      scan_start;
  logic [CNT_W-1:0]      pos_inc;
  logic [IDX_W-1:0]      pos_next;
  logic                  take;
  logic [SIZE_WIDTH-1:0] in_size;
  logic [SIZE_WIDTH-1:0] debit;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_size  = SIZE_WIDTH'(req.size_value);
  assign load_ok  = (32'(req.block_index) < NUM_BLOCKS);
  assign used_cnt = (32'(block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                    : CNT_W'(block_count);
  assign scan_start = ((fit_policy == POL_NEXT) && (CNT_W'(rover) < used_cnt))
                      ? rover : '0;
  assign pos_inc  = CNT_W'(pos) + CNT_W'(1);
  assign pos_next = (pos_inc == cnt) ? '0 : IDX_W'(pos_inc);
  assign debit    = pick_val - req_size;

  always_comb begin
    take = 1'b0;
    if (d_valid && (rd_data >= req_size)) begin
      case (fit_policy)
        POL_BEST:  take = !found || (rd_data < pick_val);
        POL_WORST: take = !found || (rd_data > pick_val);
        default:   take = !found;
      endcase
    end
  end

  assign rd_en   = (state == ST_SCAN);
  assign rd_addr = pos;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_idx;
    wr_data = debit;
    if (state == ST_DONE) begin
      wr_en = found;
    end else if (accept && (req.req_type == REQ_LOAD)) begin
      wr_en   = load_ok;
      wr_addr = IDX_W'(req.block_index);
      wr_data = in_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      d_valid <= 1'b0;
      found   <= 1'b0;
      rover   <= '0;
    end else begin
      done    <= 1'b0;
      d_valid <= (state == ST_SCAN);
      if (take) begin
        found <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.req_type == REQ_LOAD) begin
              done <= 1'b1;
              if (load_ok || req.last_request) begin
                rover <= '0;
              end
            end else if (used_cnt == '0) begin
              done <= 1'b1;
              if (req.last_request) begin
                rover <= '0;
              end
            end else begin
              found <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (left == CNT_W'(1)) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (req_last) begin
            rover <= '0;
          end else if (found && (fit_policy == POL_NEXT)) begin
            rover <= pick_idx;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    d_idx <= pos;
    if (take) begin
      pick_idx <= d_idx;
      pick_val <= rd_data;
    end
    if (state == ST_SCAN) begin
      pos  <= pos_next;
      left <= left - CNT_W'(1);
    end
    if (accept) begin
      req_size <= in_size;
      req_last <= req.last_request;
      cnt      <= used_cnt;
      pos      <= scan_start;
      left     <= used_cnt;
      if (req.req_type == REQ_LOAD && load_ok) begin
        rsp.granted        <= 1'b1;
        rsp.chosen_index   <= req.block_index;
        rsp.remaining_size <= 16'(in_size);
      end else begin
        rsp <= '0;
      end
    end else if (state == ST_DONE) begin
      if (found) begin
        rsp.granted        <= 1'b1;
        rsp.chosen_index   <= 4'(pick_idx);
        rsp.remaining_size <= 16'(debit);
      end else begin
        rsp <= '0;
      end
    end
  end

  a_wr_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_DONE && found) ||
              (accept && req.req_type == REQ_LOAD))
    else $error("table write outside load or write-back");

  a_scan_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (left != '0) && (CNT_W'(pos) < cnt))
    else $error("scan runs past the partitions in use");

  a_done_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> done && (state == ST_IDLE))
    else $error("write-back did not issue a result");

  a_grant_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && found) |=> rsp.granted)
    else $error("hit not reported as granted");

  a_rover_range: assert property (@(posedge clk) disable iff (rst)
    32'(rover) < NUM_BLOCKS)
    else $error("next fit pointer out of table");

endmodule
